FILE: sv/pts_pkg.sv
// shared constants and codes of the periodic trigger scheduler
`default_nettype none
package pts_pkg;
    localparam int DEF_TIME_WIDTH = 63;
    localparam int TIME_FIELD_W   = 63;
    localparam int COUNT_W        = 64;
    localparam int CMD_W          = 2;
    localparam int REG_INDEX_W    = 2;
    localparam int POLICY_W       = 2;

    localparam logic [TIME_FIELD_W-1:0] PERIOD_RESET = 63'd1000000;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DONE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd3;

    // policy codes
    localparam logic [POLICY_W-1:0] POL_DELAY   = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SKIP    = 2'd1;
    localparam logic [POLICY_W-1:0] POL_CATCHUP = 2'd2;

    // register indexes
    localparam logic [REG_INDEX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [REG_INDEX_W-1:0] REG_POLICY = 2'd1;
    localparam logic [REG_INDEX_W-1:0] REG_FIRE   = 2'd2;
endpackage
`default_nettype wire

FILE: sv/pts_if.sv
// handshake channels of the periodic trigger scheduler
`default_nettype none
interface pts_in_if;
    logic                                valid;
    logic                                ready;
    logic [pts_pkg::CMD_W-1:0]           command;
    logic [pts_pkg::TIME_FIELD_W-1:0]    now_time;
    modport source (output valid, command, now_time, input ready);
    modport sink   (input valid, command, now_time, output ready);
endinterface

interface pts_out_if;
    logic                                valid;
    logic                                ready;
    logic                                fired;
    logic [pts_pkg::COUNT_W-1:0]         trigger_number;
    logic [pts_pkg::COUNT_W-1:0]         skipped_before;
    logic [pts_pkg::TIME_FIELD_W-1:0]    scheduled_at;
    logic [pts_pkg::TIME_FIELD_W-1:0]    lateness;
    logic [pts_pkg::COUNT_W-1:0]         skipped_total;
    logic                                is_running;
    modport source (output valid, fired, trigger_number, skipped_before, scheduled_at,
                    lateness, skipped_total, is_running, input ready);
    modport sink   (input valid, fired, trigger_number, skipped_before, scheduled_at,
                    lateness, skipped_total, is_running, output ready);
endinterface

interface pts_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [pts_pkg::REG_INDEX_W-1:0]     reg_index;
    logic [pts_pkg::TIME_FIELD_W-1:0]    wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

FILE: sv/pts_mul.sv
// bit-serial shift-add multiplier, product clamped to the time range
`default_nettype none
module pts_mul #(
    parameter int TW = pts_pkg::DEF_TIME_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [pts_pkg::COUNT_W-1:0]        i_mcand,
    input  wire logic [pts_pkg::TIME_FIELD_W-1:0]   i_mplier,
    output logic                                    o_done,
    output logic [TW-1:0]                           o_prod
);
    localparam int CW = $clog2(pts_pkg::COUNT_W + 1);
    localparam logic [pts_pkg::COUNT_W:0] TMAX = (65'd1 << TW) - 65'd1;

    logic [pts_pkg::COUNT_W-1:0]      r_a;
    logic [pts_pkg::TIME_FIELD_W-1:0] r_b;
    logic [pts_pkg::COUNT_W-1:0]      r_acc;
    logic                             r_ovf;
    logic [CW-1:0]                    r_cnt;
    logic                             r_done;
    logic [pts_pkg::COUNT_W:0]        n_sum;

    // one multiplicand bit per cycle, msb first
    always_comb begin
        n_sum = {r_acc, 1'b0} + (r_a[pts_pkg::COUNT_W-1] ? 65'(r_b) : 65'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(pts_pkg::COUNT_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and accumulator shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_mcand;
            r_b   <= i_mplier;
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (r_cnt != '0) begin
            r_a <= {r_a[pts_pkg::COUNT_W-2:0], 1'b0};
            if (!r_ovf) begin
                if (n_sum > TMAX) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_acc <= n_sum[pts_pkg::COUNT_W-1:0];
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_ovf ? TMAX[TW-1:0] : r_acc[TW-1:0];
endmodule
`default_nettype wire

FILE: sv/pts_div.sv
// bit-serial restoring divider for slot alignment
`default_nettype none
module pts_div #(
    parameter int TW = pts_pkg::DEF_TIME_WIDTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [TW-1:0]                      i_dividend,
    input  wire logic [pts_pkg::TIME_FIELD_W-1:0]   i_divisor,
    output logic                                    o_done,
    output logic [TW-1:0]                           o_quot
);
    localparam int CW = $clog2(TW + 1);
    localparam int RW = pts_pkg::TIME_FIELD_W + 1;

    logic [TW-1:0]                    r_q;
    logic [RW-1:0]                    r_rem;
    logic [pts_pkg::TIME_FIELD_W-1:0] r_d;
    logic [CW-1:0]                    r_cnt;
    logic                             r_done;
    logic [RW-1:0]                    n_trial;
    logic                             n_ge;

    // one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem[RW-2:0], r_q[TW-1]};
        n_ge    = n_trial >= RW'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(TW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[TW-2:0], n_ge};
            r_rem <= n_ge ? (n_trial - RW'(r_d)) : n_trial;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

FILE: sv/periodic_trigger_scheduler.sv
// periodic trigger scheduler top level
//  channel  | dir | beat contents
//  i_in     | in  | command, now_time
//  o_out    | out | fired, trigger_number, skipped_before, scheduled_at, lateness,
//           |     | skipped_total, is_running
//  i_cfg    | in  | reg_index, wdata (period, policy, fire at start)
// start, poll, stop and fixed-delay done go from accept through S_OUT to the result register.
// catch-up done adds one pass of the bit-serial multiplier.
// skip done runs the multiplier, then the serial divider unless the next slot is still ahead,
// the period is 0 or now precedes the first slot, then the multiplier if slots are skipped.
// one item is in work at a time; the result register lets the next beat in
// while the previous result waits. reset is synchronous, cfg is always ready.
`default_nettype none
module periodic_trigger_scheduler #(
    parameter int TIME_WIDTH = pts_pkg::DEF_TIME_WIDTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    pts_in_if.sink       i_in,
    pts_out_if.source    o_out,
    pts_cfg_if.sink      i_cfg
);
    localparam int TW = TIME_WIDTH;
    localparam int CNT = pts_pkg::COUNT_W;
    localparam int FW = pts_pkg::TIME_FIELD_W;
    localparam logic [CNT-1:0] TMAX = (64'd1 << TW) - 64'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL2 = 6'b001000,
        S_OUT  = 6'b010000,
        S_WAIT = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [FW-1:0]                r_period;
    logic [pts_pkg::POLICY_W-1:0] r_policy;
    logic                         r_fire;
    logic r_active, n_active, r_await, n_await;
    logic [CNT-1:0] r_idx, n_idx, r_pend, n_pend, r_ssum, n_ssum, r_cand, n_cand;
    logic [TW-1:0]  r_first, n_first, r_next, n_next, r_now, n_now, r_g, n_g;
    logic           r_fired, n_fired;
    logic [CNT-1:0] r_num, n_num, r_before, n_before;
    logic [TW-1:0]  r_sched, n_sched, r_late, n_late;

    logic           r_ovalid;
    logic           r_o_fired, r_o_run;
    logic [CNT-1:0] r_o_num, r_o_before, r_o_ssum;
    logic [TW-1:0]  r_o_sched, r_o_late;

    logic           in_ready, in_fire, out_load;
    logic [TW-1:0]  now_sat, grid;
    logic [CNT-1:0] idx_inc, aligned;
    logic           mul_start, mul_done, div_start, div_done;
    logic [CNT-1:0] mul_a;
    logic [TW-1:0]  mul_prod, div_quot;

    // saturating time add
    function automatic logic [TW-1:0] tadd(input logic [TW-1:0] t, input logic [CNT-1:0] d);
        logic [CNT:0] s;
        s = 65'(t) + 65'(d);
        return (s > 65'(TMAX)) ? TMAX[TW-1:0] : s[TW-1:0];
    endfunction

    assign in_ready = (r_state == S_IDLE);
    assign in_fire  = i_in.valid && in_ready;
    assign now_sat  = (64'(i_in.now_time) > TMAX) ? TMAX[TW-1:0] : i_in.now_time[TW-1:0];
    assign idx_inc  = (r_idx == '1) ? r_idx : r_idx + 64'd1;
    assign grid     = tadd(r_first, 64'(mul_prod));
    assign aligned  = 64'(div_quot) + 64'd2;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || o_out.ready);

    pts_mul #(.TW(TW)) u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_mcand(mul_a),
        .i_mplier(r_period), .o_done(mul_done), .o_prod(mul_prod)
    );

    pts_div #(.TW(TW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_dividend(r_now - r_first), .i_divisor(r_period),
        .o_done(div_done), .o_quot(div_quot)
    );

    // command sequencer
    always_comb begin
        n_state = r_state;
        n_active = r_active; n_await = r_await; n_idx = r_idx; n_pend = r_pend;
        n_ssum = r_ssum; n_cand = r_cand; n_first = r_first; n_next = r_next;
        n_now = r_now; n_g = r_g;
        n_fired = r_fired; n_num = r_num; n_before = r_before;
        n_sched = r_sched; n_late = r_late;
        mul_start = 1'b0; mul_a = '0; div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_now = now_sat; n_state = S_OUT;
                    n_fired = 1'b0; n_num = '0; n_before = '0; n_sched = '0; n_late = '0;
                    case (i_in.command)
                        pts_pkg::CMD_START: begin
                            n_active = 1'b1; n_await = 1'b0; n_idx = 64'd1;
                            n_first = r_fire ? now_sat : tadd(now_sat, 64'(r_period));
                            n_next = n_first; n_pend = '0; n_ssum = '0;
                        end
                        pts_pkg::CMD_POLL: begin
                            if (r_active && !r_await && now_sat >= r_next) begin
                                n_fired = 1'b1; n_num = r_idx; n_before = r_pend;
                                n_sched = r_next; n_late = now_sat - r_next; n_await = 1'b1;
                            end
                        end
                        pts_pkg::CMD_DONE: begin
                            if (r_active && r_await) begin
                                n_await = 1'b0; n_pend = '0;
                                if (r_policy == pts_pkg::POL_DELAY) begin
                                    n_idx = idx_inc;
                                    n_next = tadd(now_sat, 64'(r_period));
                                end else if (r_policy == pts_pkg::POL_CATCHUP) begin
                                    n_idx = idx_inc; mul_start = 1'b1;
                                    mul_a = idx_inc - 64'd1; n_state = S_MUL2;
                                end else begin
                                    n_cand = idx_inc; mul_start = 1'b1;
                                    mul_a = idx_inc - 64'd1; n_state = S_MUL1;
                                end
                            end
                        end
                        pts_pkg::CMD_STOP: begin
                            n_active = 1'b0; n_await = 1'b0;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            // deadline of the next grid slot is known
            S_MUL1: begin
                if (mul_done) begin
                    n_g = grid;
                    if (grid > r_now || r_period == '0 || r_now < r_first) begin
                        n_idx = r_cand; n_next = grid; n_state = S_OUT;
                    end else begin
                        div_start = 1'b1; n_state = S_DIV;
                    end
                end
            end
            // first slot after now
            S_DIV: begin
                if (div_done) begin
                    if (aligned > r_cand) begin
                        n_pend = aligned - r_cand; n_ssum = r_ssum + (aligned - r_cand);
                        n_idx = aligned; mul_start = 1'b1; mul_a = aligned - 64'd1;
                        n_state = S_MUL2;
                    end else begin
                        n_idx = r_cand; n_next = r_g; n_state = S_OUT;
                    end
                end
            end
            S_MUL2: begin
                if (mul_done) begin
                    n_next = grid; n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_period <= pts_pkg::PERIOD_RESET; r_policy <= pts_pkg::POL_DELAY; r_fire <= 1'b0;
            r_active <= 1'b0; r_await <= 1'b0; r_idx <= 64'd1;
            r_first <= '0; r_next <= '0; r_pend <= '0; r_ssum <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_active <= n_active; r_await <= n_await; r_idx <= n_idx;
            r_first <= n_first; r_next <= n_next; r_pend <= n_pend; r_ssum <= n_ssum;
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    pts_pkg::REG_PERIOD: r_period <= i_cfg.wdata;
                    pts_pkg::REG_POLICY: r_policy <= i_cfg.wdata[pts_pkg::POLICY_W-1:0];
                    pts_pkg::REG_FIRE:   r_fire <= i_cfg.wdata[0];
                    default: begin
                    end
                endcase
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // work and result payload
    always_ff @(posedge i_clk) begin
        r_cand <= n_cand; r_now <= n_now; r_g <= n_g;
        r_fired <= n_fired; r_num <= n_num; r_before <= n_before;
        r_sched <= n_sched; r_late <= n_late;
        if (out_load) begin
            r_o_fired <= r_fired; r_o_num <= r_num; r_o_before <= r_before;
            r_o_sched <= r_sched; r_o_late <= r_late;
            r_o_ssum <= r_ssum; r_o_run <= r_active;
        end
    end

    assign i_in.ready           = in_ready;
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_ovalid;
    assign o_out.fired          = r_o_fired;
    assign o_out.trigger_number = r_o_num;
    assign o_out.skipped_before = r_o_before;
    assign o_out.scheduled_at   = FW'(r_o_sched);
    assign o_out.lateness       = FW'(r_o_late);
    assign o_out.skipped_total  = r_o_ssum;
    assign o_out.is_running     = r_o_run;

`ifndef SYNTH
    a_await_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_await |-> r_active) else $error("awaiting done while stopped");
    a_idx_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0) else $error("trigger index zero");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready) else $error("second beat in work");
`endif
endmodule
`default_nettype wire

FILE: tb/pts_tb_if.sv
// beat types of the scheduler testbench
`default_nettype none
package pts_tb_types;
    typedef struct packed {
        logic [1:0]  command;
        logic [62:0] now_time;
    } t_sched_cmd;

    typedef struct packed {
        logic        fired;
        logic [63:0] trigger_number;
        logic [63:0] skipped_before;
        logic [62:0] scheduled_at;
        logic [62:0] lateness;
        logic [63:0] skipped_total;
        logic        is_running;
    } t_trigger_report;
endpackage
`default_nettype wire

FILE: tb/periodic_trigger_scheduler_tb.sv
// self-checking testbench of the periodic trigger scheduler: directed and random commands, model prediction
`default_nettype none
module periodic_trigger_scheduler_tb;
    localparam logic [63:0] TMAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] UMAX = 64'hffff_ffff_ffff_ffff;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int Q_DEPTH = 1024;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pts_in_if  in_ch();
    pts_out_if out_ch();
    pts_cfg_if cfg_ch();

    periodic_trigger_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // predictor state and configuration
    logic [63:0] m_period;
    logic [1:0]  m_policy;
    logic        m_fire_start;
    logic        m_active;
    logic        m_waiting;
    logic [63:0] m_index;
    logic [63:0] m_first;
    logic [63:0] m_next;
    logic [63:0] m_pending;
    logic [63:0] m_skip_sum;

    // ring buffers of pending commands and expected reports
    pts_tb_types::t_sched_cmd      cmd_buf [Q_DEPTH];
    pts_tb_types::t_trigger_report exp_buf [Q_DEPTH];
    int  cmd_wr = 0;
    int  cmd_rd = 0;
    int  exp_wr = 0;
    int  exp_rd = 0;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  drive_en = 1'b0;
    bit  calm = 1'b0;

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] sat_inc(input logic [63:0] a, input logic [63:0] b);
        if (UMAX - a < b) return UMAX;
        return a + b;
    endfunction

    function automatic logic [63:0] time_plus(input logic [63:0] t, input logic [63:0] d);
        if (d == 64'd0) return t;
        if (t >= TMAX || d > TMAX - t) return TMAX;
        return t + d;
    endfunction

    function automatic logic [63:0] slot_time(input logic [63:0] idx);
        logic [63:0] off;
        if (idx <= 64'd1 || m_period == 64'd0) return m_first;
        off = idx - 64'd1;
        if (off > TMAX / m_period) return TMAX;
        return time_plus(m_first, off * m_period);
    endfunction

    function automatic logic [63:0] slot_after(input logic [63:0] now, input logic [63:0] lo);
        logic [63:0] al;
        if (slot_time(lo) > now) return lo;
        if (m_period == 64'd0 || now < m_first) return lo;
        al = sat_inc((now - m_first) / m_period, 64'd2);
        return (al > lo) ? al : lo;
    endfunction

    // advance scheduler state by one command and return the report it produces
    function automatic pts_tb_types::t_trigger_report schedule_step(
        input pts_tb_types::t_sched_cmd c);
        pts_tb_types::t_trigger_report r;
        logic [63:0] now, cand, al;
        r = '0;
        now = {1'b0, c.now_time};
        case (c.command)
            pts_pkg::CMD_START: begin
                m_active = 1'b1; m_waiting = 1'b0; m_index = 64'd1;
                m_first = m_fire_start ? now : time_plus(now, m_period);
                m_next = m_first; m_pending = '0; m_skip_sum = '0;
            end
            pts_pkg::CMD_POLL: begin
                if (m_active && !m_waiting && now >= m_next) begin
                    r.fired = 1'b1;
                    r.trigger_number = m_index;
                    r.skipped_before = m_pending;
                    r.scheduled_at = m_next[62:0];
                    r.lateness = now[62:0] - m_next[62:0];
                    m_waiting = 1'b1;
                end
            end
            pts_pkg::CMD_DONE: begin
                if (m_active && m_waiting) begin
                    m_waiting = 1'b0; m_pending = '0;
                    if (m_policy == pts_pkg::POL_DELAY) begin
                        m_index = sat_inc(m_index, 64'd1);
                        m_next = time_plus(now, m_period);
                    end else if (m_policy == pts_pkg::POL_CATCHUP) begin
                        m_index = sat_inc(m_index, 64'd1);
                        m_next = slot_time(m_index);
                    end else begin
                        cand = sat_inc(m_index, 64'd1);
                        al = slot_after(now, cand);
                        if (al > cand) begin
                            m_pending = al - cand;
                            m_skip_sum = m_skip_sum + m_pending;
                        end
                        m_index = al;
                        m_next = slot_time(m_index);
                    end
                end
            end
            default: begin
                m_active = 1'b0; m_waiting = 1'b0;
            end
        endcase
        r.skipped_total = m_skip_sum;
        r.is_running = m_active;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // hold the beat
        end else if (drive_en && (cmd_wr != cmd_rd)
                     && (calm || $urandom_range(99) >= 14)) begin
            pts_tb_types::t_sched_cmd c;
            c = cmd_buf[cmd_rd % Q_DEPTH];
            cmd_rd++;
            exp_buf[exp_wr % Q_DEPTH] = schedule_step(c);
            exp_wr++;
            in_ch.valid <= 1'b1;
            in_ch.command <= c.command;
            in_ch.now_time <= c.now_time;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (exp_wr == exp_rd) begin
                    report_mismatch("unexpected beat", 64'd0, 64'd0);
                end else begin
                    pts_tb_types::t_trigger_report e;
                    e = exp_buf[exp_rd % Q_DEPTH];
                    exp_rd++;
                    if (out_ch.fired !== e.fired)
                        report_mismatch("fired", 64'(out_ch.fired), 64'(e.fired));
                    if (out_ch.trigger_number !== e.trigger_number)
                        report_mismatch("trigger_number", out_ch.trigger_number,
                                        e.trigger_number);
                    if (out_ch.skipped_before !== e.skipped_before)
                        report_mismatch("skipped_before", out_ch.skipped_before,
                                        e.skipped_before);
                    if (out_ch.scheduled_at !== e.scheduled_at)
                        report_mismatch("scheduled_at", 64'(out_ch.scheduled_at),
                                        64'(e.scheduled_at));
                    if (out_ch.lateness !== e.lateness)
                        report_mismatch("lateness", 64'(out_ch.lateness),
                                        64'(e.lateness));
                    if (out_ch.skipped_total !== e.skipped_total)
                        report_mismatch("skipped_total", out_ch.skipped_total,
                                        e.skipped_total);
                    if (out_ch.is_running !== e.is_running)
                        report_mismatch("is_running", 64'(out_ch.is_running),
                                        64'(e.is_running));
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 14);
        end
    end

    // wait for all queued commands to be sent and answered
    task automatic drain();
        while (cmd_wr != cmd_rd || in_ch.valid || exp_wr != exp_rd)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write, with valid low again before the next one
    task automatic write_reg(input logic [1:0] idx, input logic [62:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == pts_pkg::REG_PERIOD) m_period = {1'b0, val};
        else if (idx == pts_pkg::REG_POLICY) m_policy = val[1:0];
        else if (idx == pts_pkg::REG_FIRE) m_fire_start = val[0];
        @(posedge i_clk);
    endtask

    function automatic void add_cmd(input logic [1:0] c, input logic [62:0] t);
        pts_tb_types::t_sched_cmd s;
        s.command = c;
        s.now_time = t;
        cmd_buf[cmd_wr % Q_DEPTH] = s;
        cmd_wr++;
    endfunction

    function automatic logic [62:0] rand_time();
        case ($urandom_range(3))
            0: return 63'({$urandom, $urandom});
            1: return 63'h7fff_ffff_ffff_ffff - 63'($urandom_range(3000));
            default: return 63'($urandom_range(100000));
        endcase
    endfunction

    // a start, then polls and dones with rising time mixed with random commands, maybe a stop
    function automatic void add_session(input int len, input logic [62:0] step);
        logic [62:0] t;
        t = ($urandom_range(3) == 0) ? rand_time() : 63'($urandom_range(5000));
        add_cmd(pts_pkg::CMD_START, t);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
                add_cmd(2'($urandom), rand_time());
            end else begin
                t = (63'h7fff_ffff_ffff_ffff - t < step) ? 63'h7fff_ffff_ffff_ffff
                    : t + 63'($urandom_range(0, int'(step)));
                add_cmd((k % 2 == 0) ? pts_pkg::CMD_POLL : pts_pkg::CMD_DONE, t);
            end
        end
        if ($urandom_range(1)) add_cmd(pts_pkg::CMD_STOP, t);
    endfunction

    // stimulus
    initial begin
        logic [62:0] per;
        int sent;
        in_ch.valid = 1'b0;
        in_ch.command = pts_pkg::CMD_START;
        in_ch.now_time = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = pts_pkg::REG_PERIOD;
        cfg_ch.wdata = '0;
        m_period = {1'b0, pts_pkg::PERIOD_RESET}; m_policy = pts_pkg::POL_DELAY;
        m_fire_start = 1'b0;
        m_active = 1'b0; m_waiting = 1'b0; m_index = 64'd1; m_first = '0; m_next = '0;
        m_pending = '0; m_skip_sum = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        drive_en = 1'b1;

        // directed: reset config, odd cases, extremes
        add_cmd(pts_pkg::CMD_POLL, 63'd5);
        add_cmd(pts_pkg::CMD_DONE, 63'd5);
        add_cmd(pts_pkg::CMD_START, 63'd0);
        add_cmd(pts_pkg::CMD_POLL, 63'd999999);
        add_cmd(pts_pkg::CMD_POLL, 63'd1000000);
        add_cmd(pts_pkg::CMD_POLL, 63'd1000001);
        add_cmd(pts_pkg::CMD_DONE, 63'd1500000);
        add_cmd(pts_pkg::CMD_POLL, 63'h7fff_ffff_ffff_ffff);
        add_cmd(pts_pkg::CMD_DONE, 63'h7fff_ffff_ffff_ffff);
        add_cmd(pts_pkg::CMD_START, 63'd100);
        add_cmd(pts_pkg::CMD_STOP, 63'd200);
        add_cmd(pts_pkg::CMD_POLL, 63'd99999999);
        drain();
        write_reg(pts_pkg::REG_POLICY, 63'(pts_pkg::POL_SKIP));
        write_reg(pts_pkg::REG_PERIOD, 63'd10);
        write_reg(pts_pkg::REG_FIRE, 63'd1);
        add_cmd(pts_pkg::CMD_START, 63'd0);
        add_cmd(pts_pkg::CMD_POLL, 63'd0);
        add_cmd(pts_pkg::CMD_DONE, 63'd95);
        add_cmd(pts_pkg::CMD_POLL, 63'd100);
        add_cmd(pts_pkg::CMD_DONE, 63'h7fff_ffff_ffff_fff0);
        add_cmd(pts_pkg::CMD_POLL, 63'h7fff_ffff_ffff_ffff);
        add_cmd(pts_pkg::CMD_START, 63'd50);
        drain();
        write_reg(pts_pkg::REG_PERIOD, 63'h7fff_ffff_ffff_ffff);
        write_reg(pts_pkg::REG_POLICY, 63'd3);
        add_cmd(pts_pkg::CMD_START, 63'd7);
        add_cmd(pts_pkg::CMD_POLL, 63'd7);
        add_cmd(pts_pkg::CMD_DONE, 63'h7fff_ffff_ffff_ffff);
        add_cmd(pts_pkg::CMD_POLL, 63'h7fff_ffff_ffff_ffff);
        drain();

        // random phases with changing configuration
        sent = 0;
        while (sent < 1150) begin
            case ($urandom_range(5))
                0: per = 63'd0;
                1: per = 63'h7fff_ffff_ffff_ffff;
                2: per = 63'({$urandom, $urandom});
                default: per = 63'($urandom_range(1, 2000));
            endcase
            write_reg(pts_pkg::REG_PERIOD, per);
            write_reg(pts_pkg::REG_POLICY, 63'($urandom_range(3)));
            write_reg(pts_pkg::REG_FIRE, 63'($urandom_range(1)));
            calm = ($urandom_range(7) == 0);
            for (int s = 0; s < 6; s++) begin
                int len;
                len = $urandom_range(4, 24);
                add_session(len, (per < 63'd4000 && $urandom_range(3) != 0)
                                 ? 63'($urandom_range(1, 6000)) : 63'd200000000);
                sent += len + 2;
            end
            drain();
        end

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
